>>> src/cardinal_spline_rasterizer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cardinal spline rasterizer
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CARDINAL_SPLINE_RASTERIZER_ASSERT_SVH
`define CARDINAL_SPLINE_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CSRAST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CSRAST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/csrast_pkg.sv
// ---------------------------------------------------------------------------
// csrast_pkg
// Constants, word types and helpers shared by the spline rasterizer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package csrast_pkg;

  // Steps per segment are 2**STEPS_LOG2 (16 .. 1024); a segment gives one sample more
  localparam int STEPS_LOG2 = 10;
  localparam int STEPS      = 1 << STEPS_LOG2;
  localparam int IDX_W      = STEPS_LOG2 + 1;

  // Coordinate width of control points (8 .. 20)
  localparam int COORD_BITS = 16;

  // Fixed-point formats
  localparam int COEF_FRAC = 8;
  localparam int TAN_SHIFT = 6;
  localparam int TAN_W     = COORD_BITS + 18;
  localparam int COEF_W    = TAN_W - 3;
  localparam int ACC_W     = 64;
  localparam int PIX_SHIFT = 3 * STEPS_LOG2 + COEF_FRAC;

  localparam logic signed [16:0] TENSION_ONE = 17'sd16384;

  // Command modes
  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TAN_W-1:0]      tangent_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } cmd_word_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               segment_end;
  } pixel_word_t;

  // Decoded command handed from the front stage to the curve stage
  typedef struct packed {
    logic     sample;
    logic     set_tan;
    logic     start;
    coord_t   p1_x;
    coord_t   p1_y;
    coord_t   p2_x;
    coord_t   p2_y;
    tangent_t tan_x;
    tangent_t tan_y;
  } seg_cmd_t;

  // Per-axis control strobes
  typedef struct packed {
    logic start;
    logic set_tan;
    logic step;
  } axis_ctl_t;

  // Read a 16-bit field as a COORD_BITS two's complement value
  function automatic coord_t coord_of(input logic [15:0] v);
    logic [31:0] w;
    w = {16'b0, v};
    return coord_t'(w[COORD_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

>>> src/csrast_front.sv
// ---------------------------------------------------------------------------
// csrast_front
// Input register, control point history and tangent multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module csrast_front import csrast_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [15:0] tension,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire cmd_word_t          cmd,
  output logic                    seg_valid,
  input  wire logic               seg_ready,
  output seg_cmd_t                seg
);

  localparam logic [1:0] SEEN_TAN  = 2'd2;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  logic                        s1_valid;
  cmd_word_t                   s1;
  logic                        s1_fire;
  logic                        s1_push;
  coord_t                      older_x, older_y, newer_x, newer_y;
  logic [1:0]                  points_seen;
  coord_t                      px, py;
  logic signed [16:0]          c1;
  logic signed [COORD_BITS:0]  diff_x, diff_y;
  tangent_t                    tan_x, tan_y;
  seg_cmd_t                    seg_next;

  // Move the held word on when the curve stage has room
  assign s1_fire   = s1_valid && (!seg_valid || seg_ready);
  assign cmd_ready = !s1_valid || s1_fire;
  assign s1_push   = (s1.mode == MODE_PUSH);

  // Tangent against the older kept point: (1 - c) * (p - older)
  assign px     = coord_of(s1.point_x);
  assign py     = coord_of(s1.point_y);
  assign c1     = TENSION_ONE - 17'(tension);
  assign diff_x = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(older_x);
  assign diff_y = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(older_y);
  assign tan_x  = TAN_W'(c1) * TAN_W'(diff_x);
  assign tan_y  = TAN_W'(c1) * TAN_W'(diff_y);

  // Decode the word for the curve stage
  always_comb begin
    seg_next.sample  = (s1.mode == MODE_SAMPLE);
    seg_next.set_tan = s1_push && (points_seen == SEEN_TAN);
    seg_next.start   = s1_push && (points_seen == SEEN_FULL);
    seg_next.p1_x    = older_x;
    seg_next.p1_y    = older_y;
    seg_next.p2_x    = newer_x;
    seg_next.p2_y    = newer_y;
    seg_next.tan_x   = tan_x;
    seg_next.tan_y   = tan_y;
  end

  // Control state and point history
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      seg_valid   <= 1'b0;
      older_x     <= '0;
      older_y     <= '0;
      newer_x     <= '0;
      newer_y     <= '0;
      points_seen <= '0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
      if (s1_fire && s1_push) begin
        older_x <= newer_x;
        older_y <= newer_y;
        newer_x <= px;
        newer_y <= py;
        if (points_seen != SEEN_FULL) begin
          points_seen <= points_seen + 2'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s1 <= cmd;
    end
    if (s1_fire) begin
      seg <= seg_next;
    end
  end

endmodule

`default_nettype wire

>>> src/csrast_axis.sv
// ---------------------------------------------------------------------------
// csrast_axis
// Hermite setup, forward-difference accumulators and pixel rounding, one axis.
// ---------------------------------------------------------------------------
`default_nettype none

module csrast_axis import csrast_pkg::*; (
  input  wire logic               clk,
  input  wire axis_ctl_t          ctl,
  input  wire coord_t             p1,
  input  wire coord_t             p2,
  input  wire tangent_t           tan,
  output logic signed [15:0]      pix
);

  localparam logic [ACC_W-1:0]        ROUND_HALF = ACC_W'(1) << (PIX_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] PIX_MAX    = 64'sd32767;
  localparam logic signed [ACC_W-1:0] PIX_MIN    = -64'sd32768;

  tangent_t                       prev_tan;
  logic [ACC_W-1:0]               acc [4];
  logic signed [TAN_W-TAN_SHIFT-1:0] t1, t2;
  logic signed [COEF_W-1:0]       q1c, q2c, t1c, t2c, dq, a2, a3;
  logic signed [ACC_W-1:0]        a0w, t1w, a2w, a3w;
  logic [ACC_W-1:0]               rsum;
  logic signed [ACC_W-1:0]        pwide;

  // Hermite coefficients in Q8: tangents floor-divided by 64
  assign t1  = $signed(prev_tan[TAN_W-1:TAN_SHIFT]);
  assign t2  = $signed(tan[TAN_W-1:TAN_SHIFT]);
  assign q1c = COEF_W'(p1) <<< COEF_FRAC;
  assign q2c = COEF_W'(p2) <<< COEF_FRAC;
  assign t1c = COEF_W'(t1);
  assign t2c = COEF_W'(t2);
  assign dq  = q2c - q1c;
  assign a2  = (dq <<< 1) + dq - (t1c <<< 1) - t2c;
  assign a3  = t1c + t2c - (dq <<< 1);

  assign a0w = ACC_W'(q1c);
  assign t1w = ACC_W'(t1c);
  assign a2w = ACC_W'(a2);
  assign a3w = ACC_W'(a3);

  // Round half up, scale down, saturate
  assign rsum  = acc[0] + ROUND_HALF;
  assign pwide = $signed(rsum) >>> PIX_SHIFT;

  always_comb begin
    priority if (pwide > PIX_MAX) begin
      pix = 16'sh7fff;
    end else if (pwide < PIX_MIN) begin
      pix = -16'sh8000;
    end else begin
      pix = $signed(pwide[15:0]);
    end
  end

  // Latch a tangent, load a new segment or advance one step
  always_ff @(posedge clk) begin
    if (ctl.start || ctl.set_tan) begin
      prev_tan <= tan;
    end
    priority if (ctl.start) begin
      acc[0] <= a0w <<< (3 * STEPS_LOG2);
      acc[1] <= (t1w <<< (2 * STEPS_LOG2)) + (a2w <<< STEPS_LOG2) + a3w;
      acc[2] <= (a2w <<< (STEPS_LOG2 + 1)) + (a3w <<< 2) + (a3w <<< 1);
      acc[3] <= (a3w <<< 2) + (a3w <<< 1);
    end else if (ctl.step) begin
      acc[0] <= acc[0] + acc[1];
      acc[1] <= acc[1] + acc[2];
      acc[2] <= acc[2] + acc[3];
    end
  end

endmodule

`default_nettype wire

>>> src/cardinal_spline_rasterizer.sv
// A sample word reaches pixel through the input register, the segment command
// register (which holds the tangents) and the output register.
// Throughput: one command word per cycle, push or sample, unless the output stalls;
// a push that opens a segment and a sample right behind it both pass at full rate.
// Reset (rst, synchronous, active high) empties the pipeline, clears the point
// history and segment state, and sets tension to zero.
// ---------------------------------------------------------------------------
// cardinal_spline_rasterizer
// Cardinal spline rasterizer: control points in, Hermite segment samples out.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cardinal_spline_rasterizer_assert.svh"

module cardinal_spline_rasterizer import csrast_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire cmd_word_t          cmd,
  output logic                    pixel_valid,
  input  wire logic               pixel_ready,
  output pixel_word_t             pixel
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS);

  logic signed [15:0] tension;
  logic               seg_valid;
  logic               seg_ready;
  seg_cmd_t           seg;
  logic               seg_active;
  logic [IDX_W-1:0]   sample_index;
  logic               emit;
  logic               seg_fire;
  logic               last;
  axis_ctl_t          ctl;
  logic signed [15:0] pix_x, pix_y;

  // Tension register
  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= '0;
    end else if (cfg_we) begin
      tension <= $signed(cfg_wdata);
    end
  end

  csrast_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tension   (tension),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  // Only a sample that emits needs a free output register
  assign emit      = seg.sample && seg_active;
  assign seg_ready = !emit || !pixel_valid || pixel_ready;
  assign seg_fire  = seg_valid && seg_ready;
  assign last      = (sample_index == LAST_IDX);

  assign ctl.start   = seg_fire && seg.start;
  assign ctl.set_tan = seg_fire && seg.set_tan;
  assign ctl.step    = seg_fire && emit;

  csrast_axis u_axis_x (
    .clk (clk),
    .ctl (ctl),
    .p1  (seg.p1_x),
    .p2  (seg.p2_x),
    .tan (seg.tan_x),
    .pix (pix_x)
  );

  csrast_axis u_axis_y (
    .clk (clk),
    .ctl (ctl),
    .p1  (seg.p1_y),
    .p2  (seg.p2_y),
    .tan (seg.tan_y),
    .pix (pix_y)
  );

  // Segment state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_active   <= 1'b0;
      sample_index <= '0;
      pixel_valid  <= 1'b0;
    end else begin
      priority if (ctl.start) begin
        seg_active   <= 1'b1;
        sample_index <= '0;
      end else if (ctl.step) begin
        if (last) begin
          seg_active   <= 1'b0;
          sample_index <= '0;
        end else begin
          sample_index <= sample_index + IDX_W'(1);
        end
      end
      if (ctl.step) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      pixel.pixel_x     <= pix_x;
      pixel.pixel_y     <= pix_y;
      pixel.segment_end <= last;
    end
  end

  `CSRAST_ASSERT_SAME(a_idle_index_zero, !seg_active, sample_index == '0,
    "sample index not zero without a segment")
  `CSRAST_ASSERT_NEXT(a_last_closes, ctl.step && last, !seg_active,
    "segment still active after its final sample")
  `CSRAST_ASSERT_NEXT(a_start_opens, ctl.start, seg_active && sample_index == '0,
    "new segment did not restart at the first sample")
  `CSRAST_ASSERT_NEXT(a_end_flag, ctl.step, pixel_valid && pixel.segment_end == $past(last),
    "segment end flag does not match the sample index")

endmodule

`default_nettype wire

>>> verif/spline_pixel_checker.sv
// ---------------------------------------------------------------------------
// spline_pixel_checker
// Watches the tension writes and both word channels of the spline rasterizer,
// predicts every pixel word from the accepted command words, and compares
// each pixel word, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module spline_pixel_checker import csrast_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        cmd_valid,
  input  logic        cmd_ready,
  input  cmd_word_t   cmd,
  input  logic        pixel_valid,
  input  logic        pixel_ready,
  input  pixel_word_t pixel,
  output int          mismatches,
  output int          outstanding
);

  localparam int     FRAC_BITS  = 8;
  localparam int     TAN_DROP   = 6;
  localparam longint UNIT_Q14   = 16384;
  localparam longint SPAN       = STEPS;
  localparam longint SPAN3      = SPAN * SPAN * SPAN;
  localparam int     OUT_SHIFT  = 3 * $clog2(STEPS) + FRAC_BITS;
  localparam longint ROUND_HALF = longint'(1) << (OUT_SHIFT - 1);

  // Cubic value and its first, second and third forward difference
  typedef bit [3:0][63:0] diffs_t;

  longint      tension;
  longint      back_x, back_y, front_x, front_y;
  longint      slope_x, slope_y;
  int          points_held;
  diffs_t      curve_x, curve_y;
  int          next_k;
  bit          drawing;
  int          fail_tally;
  pixel_word_t pending_pixels[$];

  // Set up the differences of the Hermite cubic between p1 and p2 (Q14 tangents)
  function automatic diffs_t hermite_diffs(longint p1, longint t1q, longint p2, longint t2q);
    longint    q1, q2, t1, t2, a2, a3;
    bit [63:0] ca, cb, cc, cd;
    diffs_t    d;
    q1 = p1 * (longint'(1) << FRAC_BITS);
    q2 = p2 * (longint'(1) << FRAC_BITS);
    t1 = t1q >>> TAN_DROP;
    t2 = t2q >>> TAN_DROP;
    a2 = -3 * q1 - 2 * t1 + 3 * q2 - t2;
    a3 = 2 * q1 + t1 - 2 * q2 + t2;
    ca = q1 * SPAN3;
    cb = t1 * SPAN * SPAN;
    cc = a2 * SPAN;
    cd = a3;
    d[0] = ca;
    d[1] = cb + cc + cd;
    d[2] = 2 * cc + 6 * cd;
    d[3] = 6 * cd;
    return d;
  endfunction

  // Round the scaled cubic to the nearest pixel and clamp to 16 bits
  function automatic logic signed [15:0] to_pixel(bit [63:0] p);
    longint v;
    v = longint'(p + ROUND_HALF) >>> OUT_SHIFT;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Move the cubic one sample forward
  function automatic diffs_t advance(diffs_t d);
    d[0] = d[0] + d[1];
    d[1] = d[1] + d[2];
    d[2] = d[2] + d[3];
    return d;
  endfunction

  // Update the point history on a push, or queue the next sample on a request
  task automatic take_command(cmd_word_t w);
    longint      px, py, tx, ty;
    pixel_word_t exp_word;
    if (w.mode == MODE_PUSH) begin
      px = longint'(w.point_x);
      py = longint'(w.point_y);
      tx = (UNIT_Q14 - tension) * (px - back_x);
      ty = (UNIT_Q14 - tension) * (py - back_y);
      if (points_held == 2) begin
        slope_x = tx;
        slope_y = ty;
      end else if (points_held == 3) begin
        curve_x = hermite_diffs(back_x, slope_x, front_x, tx);
        curve_y = hermite_diffs(back_y, slope_y, front_y, ty);
        slope_x = tx;
        slope_y = ty;
        next_k  = 0;
        drawing = 1'b1;
      end
      back_x  = front_x;
      back_y  = front_y;
      front_x = px;
      front_y = py;
      if (points_held < 3) points_held++;
    end else if (drawing) begin
      exp_word.pixel_x     = to_pixel(curve_x[0]);
      exp_word.pixel_y     = to_pixel(curve_y[0]);
      exp_word.segment_end = (next_k >= STEPS);
      curve_x = advance(curve_x);
      curve_y = advance(curve_y);
      if (next_k >= STEPS) begin
        drawing = 1'b0;
        next_k  = 0;
      end else begin
        next_k++;
      end
      pending_pixels.push_back(exp_word);
    end
  endtask

  // Compare one pixel word with the oldest prediction
  task automatic check_pixel(pixel_word_t got);
    pixel_word_t want;
    if (pending_pixels.size() == 0) begin
      $error("pixel word with none expected: x %0d y %0d end %0b",
             got.pixel_x, got.pixel_y, got.segment_end);
      fail_tally++;
    end else begin
      want = pending_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
        fail_tally++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
        fail_tally++;
      end
      if (got.segment_end !== want.segment_end) begin
        $error("segment_end: expected %0b, got %0b", want.segment_end, got.segment_end);
        fail_tally++;
      end
    end
  endtask

  initial fail_tally = 0;

  // Track writes and words at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      tension     = 0;
      back_x      = 0;
      back_y      = 0;
      front_x     = 0;
      front_y     = 0;
      slope_x     = 0;
      slope_y     = 0;
      points_held = 0;
      curve_x     = '0;
      curve_y     = '0;
      next_k      = 0;
      drawing     = 1'b0;
      pending_pixels.delete();
    end else begin
      if (cfg_we) tension = longint'($signed(cfg_wdata));
      if (cmd_valid && cmd_ready) take_command(cmd);
      if (pixel_valid && pixel_ready) check_pixel(pixel);
    end
    outstanding <= pending_pixels.size();
    mismatches  <= fail_tally;
  end

endmodule

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives the spline rasterizer with control point pushes and sample requests
// under random source gaps and sink stalls, over a range of tension settings,
// and gives the verdict from the checker's mismatch and outstanding counts.
// ---------------------------------------------------------------------------
module tb;
  import csrast_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int STALL_MAX      = 15;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int LONG_PHASE     = 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_word_t   cmd = '0;
  logic        pixel_valid;
  logic        pixel_ready = 1'b0;
  pixel_word_t pixel;
  int          mismatches;
  int          outstanding;

  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  int points_sent   = 0;
  int samples_left  = 0;
  int counted       = 0;
  int idle_cycles   = 0;

  always #(HALF_PERIOD) clk = ~clk;

  cardinal_spline_rasterizer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  spline_pixel_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Pick a coordinate: edges of the range, anywhere, or on screen
  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  // Send one command word after a random gap and hold it until taken
  task automatic send_word(input logic op, input logic signed [15:0] x,
                           input logic signed [15:0] y);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{mode: op, point_x: x, point_y: y};
    do @(posedge clk); while (!cmd_ready);
    // count pushes and requests that draw a pixel
    if (op == MODE_PUSH) begin
      counted++;
      if (points_sent == 3) samples_left = STEPS + 1;
      else points_sent++;
    end else if (samples_left > 0) begin
      counted++;
      samples_left--;
    end
  endtask

  // Drop valid and wait until every predicted pixel word has drained
  task automatic settle();
    @(negedge clk) cmd_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tension(input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sink: stall a random number of cycles before each pixel word
  initial begin : sink
    int stall;
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, STALL_MAX);
      repeat (stall) @(negedge clk) pixel_ready <= 1'b0;
      @(negedge clk) pixel_ready <= 1'b1;
      do @(posedge clk); while (!pixel_valid);
      if ($urandom_range(0, 31) == 0) sink_quiet = !sink_quiet;
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (pixel_valid && pixel_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("cardinal_spline_rasterizer verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          phase;
    int          stop_at;
    int          pick;
    int          pushes;
    logic [15:0] setting;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // request with no points at all
    send_word(MODE_SAMPLE, 16'sh0, 16'sh0);
    // first three points only fill history; third sets the first tangent
    send_word(MODE_PUSH, 16'sd0, 16'sd0);
    send_word(MODE_PUSH, 16'sd100, 16'sd50);
    send_word(MODE_PUSH, 16'sd200, -16'sd40);
    send_word(MODE_SAMPLE, 16'sh0, 16'sh0);
    // fourth point opens the first segment
    send_word(MODE_PUSH, 16'sd300, 16'sd10);
    repeat (4) send_word(MODE_SAMPLE, 16'sh0, 16'sh0);
    // replace an unfinished segment, with range extremes
    send_word(MODE_PUSH, 16'sh7FFF, 16'sh8000);
    repeat (3) send_word(MODE_SAMPLE, 16'shFFFF, 16'shFFFF);
    send_word(MODE_PUSH, 16'sh8000, 16'sh7FFF);
    repeat (3) send_word(MODE_SAMPLE, 16'sh7FFF, 16'sh8000);
    send_word(MODE_PUSH, -16'sd1, -16'sd1);
    repeat (2) send_word(MODE_SAMPLE, 16'sh8000, 16'sh7FFF);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0:       setting = 16'h7FFF;
        1:       setting = 16'h8000;
        2:       setting = 16'h4000;
        3:       setting = 16'hC000;
        5:       setting = 16'h0000;
        7:       setting = 16'h2000;
        default: setting = 16'($urandom);
      endcase
      write_tension(setting);
      stop_at = counted + PHASE_ITEMS;

      // run one segment to its end and past it
      if (phase == LONG_PHASE) begin
        send_word(MODE_PUSH, pick_coord(), pick_coord());
        repeat (STEPS + 4) send_word(MODE_SAMPLE, 16'($urandom), 16'($urandom));
      end

      // bursts of pushes followed by runs of sample requests
      while (counted < stop_at) begin
        src_quiet = ($urandom_range(0, 3) == 0);
        pick      = $urandom_range(0, 7);
        pushes    = (pick < 5) ? 1 : ((pick < 7) ? $urandom_range(2, 4) : 0);
        repeat (pushes) send_word(MODE_PUSH, pick_coord(), pick_coord());
        repeat ($urandom_range(0, 48))
          send_word(MODE_SAMPLE, 16'($urandom), 16'($urandom));
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("cardinal_spline_rasterizer verification clean");
    end else begin
      $display("cardinal_spline_rasterizer verification failed");
    end
    $finish;
  end

endmodule
